@@ src/scba_pkg.sv @@
// ----------------------------------------------------------------------------
// scba_pkg
// Shared constants, codes and types of the size class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int NUM_CLASSES      = 4;
    localparam int BLOCKS_PER_CLASS = 1024;
    localparam int WORD_BITS        = 64;
    localparam int ROWS_PER_CLASS   = BLOCKS_PER_CLASS / WORD_BITS;
    localparam int CLS_W            = 2;
    localparam int ROW_W            = $clog2(ROWS_PER_CLASS);
    localparam int BIT_W            = $clog2(WORD_BITS);
    localparam int BLK_W            = 10;
    localparam int CNT_W            = 11;
    localparam int BYTES_W          = 16;
    localparam int ADDR_W           = CLS_W + ROW_W;
    localparam int MAP_ROWS         = NUM_CLASSES * ROWS_PER_CLASS;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_CLASS = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_BYTES0 = 3'd0,
        REG_BYTES1 = 3'd1,
        REG_BYTES2 = 3'd2,
        REG_BYTES3 = 3'd3,
        REG_COUNT0 = 3'd4,
        REG_COUNT1 = 3'd5,
        REG_COUNT2 = 3'd6,
        REG_COUNT3 = 3'd7
    } reg_index_t;

endpackage

@@ src/scba_ram.sv @@
// ----------------------------------------------------------------------------
// scba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/size_class_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// size_class_block_allocator_core
// Four-class fixed-block pool allocator; used bitmap in RAM, 64-bit words,
// with per-word full and valid summary flops.
// ----------------------------------------------------------------------------
//  channel  | ports                    | transfer
//  ---------+--------------------------+------------------------------
//  request  | s_valid/s_ready, s_*     | one transaction per request
//  result   | m_valid/m_ready, m_*     | one transaction per request
//  config   | cfg_wr_en/index/wr_data  | write on enable, no wait
//
//  m_valid rises after acceptance through a select state that also issues
//  the RAM read, then a modify and write-back state. A new request is taken
//  only in idle, once the read-modify-write of one bitmap word is done.
//  Reset and count writes clear the map at once through per-word valid bits.
//  A result held by m_ready low stalls the next request in the write-back stage.
// ----------------------------------------------------------------------------
module size_class_block_allocator_core
    import scba_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [BYTES_W-1:0]   cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [BYTES_W-1:0]   s_request_bytes,
    input  logic [CLS_W-1:0]     s_free_class,
    input  logic [BLK_W-1:0]     s_free_block,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_granted,
    output logic [1:0]           m_status,
    output logic [CLS_W-1:0]     m_grant_class,
    output logic [BLK_W-1:0]     m_grant_block,
    output logic [CNT_W-1:0]     m_class_free_count,
    output logic [CNT_W-1:0]     m_class_used_count
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEL  = 3'b010,
        ST_MOD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [BYTES_W-1:0] bytes_reg [NUM_CLASSES];
    logic [CNT_W-1:0]   count_reg [NUM_CLASSES];
    logic [CNT_W-1:0]   used_reg  [NUM_CLASSES];
    logic [MAP_ROWS-1:0] full_reg;
    logic [MAP_ROWS-1:0] valid_reg;

    logic               mode_reg;
    logic [BYTES_W-1:0] req_reg;
    logic [CLS_W-1:0]   fc_reg;
    logic [BLK_W-1:0]   fb_reg;
    logic [CLS_W-1:0]   cls_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               nocls_reg;
    logic               nofree_reg;

    logic               m_valid_reg;
    logic               granted_reg;
    status_t            status_reg;
    logic [CLS_W-1:0]   gcls_reg;
    logic [BLK_W-1:0]   gblk_reg;
    logic [CNT_W-1:0]   fcnt_reg;
    logic [CNT_W-1:0]   ucnt_reg;

    // select stage
    logic               sel_found;
    logic [CLS_W-1:0]   sel_cls;
    logic [ROW_W-1:0]   sel_row;
    logic               sel_nofree;
    logic [ADDR_W-1:0]  rd_addr;

    always_comb begin
        sel_found  = 1'b0;
        sel_cls    = '0;
        sel_row    = '0;
        sel_nofree = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (bytes_reg[c] >= req_reg &&
                (!sel_found || bytes_reg[c] < bytes_reg[sel_cls])) begin
                sel_cls   = CLS_W'(c);
                sel_found = 1'b1;
            end
        end
        if (mode_reg) begin
            sel_cls    = fc_reg;
            sel_row    = fb_reg[BLK_W-1:BIT_W];
            sel_nofree = 1'b0;
        end else begin
            for (int r = ROWS_PER_CLASS - 1; r >= 0; r--) begin
                if (!full_reg[{sel_cls, ROW_W'(r)}]) begin
                    sel_row    = ROW_W'(r);
                    sel_nofree = 1'b0;
                end
            end
        end
        rd_addr = {sel_cls, sel_row};
    end

    // modify stage
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] word_new;
    logic [BIT_W-1:0]     zero_idx;
    logic                 zero_found;
    logic [CNT_W-1:0]     n_eff;
    logic [CNT_W-1:0]     u_cur;
    logic [CNT_W-1:0]     u_new;
    logic [BLK_W-1:0]     alloc_blk;
    logic                 do_write;
    logic                 mod_granted;
    status_t              mod_status;
    logic [BLK_W-1:0]     mod_blk;
    logic                 cls_absent;
    logic                 mod_fire;

    assign addr     = {cls_reg, row_reg};
    assign word     = valid_reg[addr] ? rd_data : '0;
    assign mod_fire = (state_reg == ST_MOD) && (!m_valid_reg || m_ready);

    always_comb begin
        zero_idx   = '0;
        zero_found = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                zero_idx   = BIT_W'(i);
                zero_found = 1'b1;
            end
        end
        n_eff = (count_reg[cls_reg] > CNT_W'(BLOCKS_PER_CLASS)) ?
                CNT_W'(BLOCKS_PER_CLASS) : count_reg[cls_reg];
        u_cur       = used_reg[cls_reg];
        u_new       = u_cur;
        alloc_blk   = {row_reg, zero_idx};
        word_new    = word;
        do_write    = 1'b0;
        mod_granted = 1'b0;
        mod_status  = STATUS_OK;
        mod_blk     = '0;
        cls_absent  = ({1'b0, fc_reg} >= (CLS_W + 1)'(NUM_CLASSES));
        if (!mode_reg) begin
            if (nocls_reg) begin
                mod_status = STATUS_NO_CLASS;
            end else if (nofree_reg || !zero_found ||
                         {1'b0, alloc_blk} >= n_eff) begin
                mod_status = STATUS_EMPTY;
            end else begin
                mod_granted        = 1'b1;
                mod_blk            = alloc_blk;
                word_new[zero_idx] = 1'b1;
                do_write           = 1'b1;
                u_new              = u_cur + CNT_W'(1);
            end
        end else begin
            mod_blk = fb_reg;
            if (cls_absent || {1'b0, fb_reg} >= n_eff) begin
                mod_status = STATUS_BAD_FREE;
            end else if (word[fb_reg[BIT_W-1:0]]) begin
                word_new[fb_reg[BIT_W-1:0]] = 1'b0;
                do_write                    = 1'b1;
                u_new                       = u_cur - CNT_W'(1);
            end
        end
    end

    scba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_ROWS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (mod_fire && do_write),
        .wr_addr (addr),
        .wr_data (word_new),
        .rd_en   (state_reg == ST_SEL),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_SEL;
            ST_SEL:  state_next = ST_MOD;
            ST_MOD:  if (mod_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            full_reg    <= '0;
            valid_reg   <= '0;
            bytes_reg   <= '{16'd64, 16'd128, 16'd512, 16'd1024};
            count_reg   <= '{11'd1024, 11'd512, 11'd128, 11'd64};
            used_reg    <= '{default: '0};
        end else begin
            state_reg <= state_next;
            if (mod_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en && cfg_index <= REG_BYTES3) begin
                bytes_reg[cfg_index[CLS_W-1:0]] <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index > REG_BYTES3) begin
                count_reg[cfg_index[CLS_W-1:0]] <= cfg_wr_data[CNT_W-1:0];
                full_reg  <= '0;
                valid_reg <= '0;
                used_reg  <= '{default: '0};
            end else if (mod_fire && do_write) begin
                valid_reg[addr]   <= 1'b1;
                full_reg[addr]    <= &word_new;
                used_reg[cls_reg] <= u_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            req_reg  <= s_request_bytes;
            fc_reg   <= s_free_class;
            fb_reg   <= s_free_block;
        end
        if (state_reg == ST_SEL) begin
            cls_reg    <= sel_cls;
            row_reg    <= sel_row;
            nocls_reg  <= !sel_found;
            nofree_reg <= sel_nofree;
        end
        if (mod_fire) begin
            granted_reg <= mod_granted;
            status_reg  <= mod_status;
            gblk_reg    <= mod_blk;
            if (!mode_reg && nocls_reg) begin
                gcls_reg <= '0;
                fcnt_reg <= '0;
                ucnt_reg <= '0;
            end else if (mode_reg && cls_absent) begin
                gcls_reg <= fc_reg;
                fcnt_reg <= '0;
                ucnt_reg <= '0;
            end else begin
                gcls_reg <= cls_reg;
                fcnt_reg <= (n_eff > u_new) ? n_eff - u_new : '0;
                ucnt_reg <= u_new;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_granted          = granted_reg;
    assign m_status           = status_reg;
    assign m_grant_class      = gcls_reg;
    assign m_grant_block      = gblk_reg;
    assign m_class_free_count = fcnt_reg;
    assign m_class_used_count = ucnt_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_class_used_count <= CNT_W'(BLOCKS_PER_CLASS))
        else $error("used count above class capacity");

    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> m_status == STATUS_OK)
        else $error("grant with failing status");

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("request accepted during work");

endmodule

@@ sim/tb_size_class_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// tb_size_class_block_allocator_core
// Drives allocate and free transactions into the pool allocator under random
// idling and back pressure, predicts each result from a local model of the
// class bitmaps and counts, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_size_class_block_allocator_core;
    import scba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                mode;
        logic [BYTES_W-1:0]  request_bytes;
        logic [CLS_W-1:0]    free_class;
        logic [BLK_W-1:0]    free_block;
    } pool_req_t;

    typedef struct packed {
        logic                granted;
        logic [1:0]          status;
        logic [CLS_W-1:0]    grant_class;
        logic [BLK_W-1:0]    grant_block;
        logic [CNT_W-1:0]    free_count;
        logic [CNT_W-1:0]    used_count;
    } pool_rsp_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [BYTES_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic [BYTES_W-1:0] s_request_bytes = '0;
    logic [CLS_W-1:0] s_free_class = '0;
    logic [BLK_W-1:0] s_free_block = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_granted;
    logic [1:0] m_status;
    logic [CLS_W-1:0] m_grant_class;
    logic [BLK_W-1:0] m_grant_block;
    logic [CNT_W-1:0] m_class_free_count;
    logic [CNT_W-1:0] m_class_used_count;

    size_class_block_allocator_core DUT (.*);

    // predictor state
    logic [BYTES_W-1:0] cls_bytes [NUM_CLASSES];
    logic [CNT_W-1:0]   cls_count [NUM_CLASSES];
    bit                 blk_used  [NUM_CLASSES][BLOCKS_PER_CLASS];
    int                 cls_used  [NUM_CLASSES];

    pool_req_t pending_reqs[$];
    pool_rsp_t expected_rsps[$];
    int  errors = 0;
    int  cycles = 0;
    bit  hold_off = 1'b0;
    bit  send_pause = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_cnt = 0;
    int  sent_cnt = 0;
    int  taken_cnt = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int live_count(int c);
        return (cls_count[c] > BLOCKS_PER_CLASS) ? BLOCKS_PER_CLASS : int'(cls_count[c]);
    endfunction

    function automatic pool_rsp_t class_rsp(bit g, status_t st, int c, int blk);
        pool_rsp_t r;
        int n;
        n = live_count(c);
        r.granted = g;
        r.status = st;
        r.grant_class = CLS_W'(c);
        r.grant_block = BLK_W'(blk);
        r.free_count = CNT_W'((n > cls_used[c]) ? n - cls_used[c] : 0);
        r.used_count = CNT_W'(cls_used[c]);
        return r;
    endfunction

    function automatic void clear_pool();
        foreach (blk_used[c, b]) blk_used[c][b] = 1'b0;
        foreach (cls_used[c]) cls_used[c] = 0;
    endfunction

    function automatic pool_rsp_t allocate_or_free(pool_req_t q);
        int best;
        int n;
        best = -1;
        if (q.mode == 1'b0) begin
            for (int c = 0; c < NUM_CLASSES; c++)
                if (cls_bytes[c] >= q.request_bytes &&
                    (best < 0 || cls_bytes[c] < cls_bytes[best])) best = c;
            if (best < 0) return '{default: '0, status: STATUS_NO_CLASS};
            n = live_count(best);
            for (int b = 0; b < n; b++)
                if (!blk_used[best][b]) begin
                    blk_used[best][b] = 1'b1;
                    cls_used[best]++;
                    return class_rsp(1'b1, STATUS_OK, best, b);
                end
            return class_rsp(1'b0, STATUS_EMPTY, best, 0);
        end
        if (q.free_block >= live_count(q.free_class))
            return class_rsp(1'b0, STATUS_BAD_FREE, q.free_class, q.free_block);
        if (blk_used[q.free_class][q.free_block]) begin
            blk_used[q.free_class][q.free_block] = 1'b0;
            cls_used[q.free_class]--;
        end
        return class_rsp(1'b0, STATUS_OK, q.free_class, q.free_block);
    endfunction

    function automatic void add_req(pool_req_t q);
        pending_reqs = {pending_reqs, q};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic write_reg(reg_index_t idx, int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= BYTES_W'(value);
        if (idx >= REG_COUNT0) begin
            cls_count[CLS_W'(idx - REG_COUNT0)] = CNT_W'(value);
            clear_pool();
        end else begin
            cls_bytes[CLS_W'(idx)] = BYTES_W'(value);
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic pool_req_t alloc_req(int bytes);
        return '{mode: 1'b0, request_bytes: BYTES_W'(bytes), free_class: CLS_W'($urandom),
                 free_block: BLK_W'($urandom)};
    endfunction

    function automatic pool_req_t free_req(int c, int b);
        return '{mode: 1'b1, request_bytes: BYTES_W'($urandom), free_class: CLS_W'(c),
                 free_block: BLK_W'(b)};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && sent_cnt != taken_cnt) begin
            end else if (send_gap > 0 || send_pause) begin
                if (s_valid) s_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                pool_req_t q;
                q = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_mode <= q.mode;
                s_request_bytes <= q.request_bytes;
                s_free_class <= q.free_class;
                s_free_block <= q.free_block;
                sent_cnt <= sent_cnt + 1;
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // record each accepted transaction and its expected result
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            taken_cnt <= taken_cnt + 1;
            expected_rsps = {expected_rsps, allocate_or_free(
                '{s_mode, s_request_bytes, s_free_class, s_free_block})};
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off && hold_cnt < HOLD_CYCLES) begin
            m_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else if (recv_gap > 0) begin
            m_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_ready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                pool_rsp_t e;
                e = expected_rsps.pop_front();
                if (m_granted !== e.granted) report_mismatch("granted", m_granted, e.granted);
                if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                if (m_grant_class !== e.grant_class)
                    report_mismatch("grant_class", m_grant_class, e.grant_class);
                if (m_grant_block !== e.grant_block)
                    report_mismatch("grant_block", m_grant_block, e.grant_block);
                if (m_class_free_count !== e.free_count)
                    report_mismatch("free_count", m_class_free_count, e.free_count);
                if (m_class_used_count !== e.used_count)
                    report_mismatch("used_count", m_class_used_count, e.used_count);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic random_phase(int items, int max_bytes);
        int c;
        for (int i = 0; i < items; i++) begin
            c = $urandom_range(0, NUM_CLASSES - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: add_req(alloc_req($urandom_range(0, max_bytes)));
                5:       add_req(alloc_req($urandom));
                6, 7, 8: add_req(free_req(c,
                             $urandom_range(0, (live_count(c) > 0) ? live_count(c) : 1)));
                default: add_req(free_req(c, $urandom));
            endcase
        end
    endtask

    initial begin
        cls_bytes = '{16'd64, 16'd128, 16'd512, 16'd1024};
        cls_count = '{11'd1024, 11'd512, 11'd128, 11'd64};
        clear_pool();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, each status, double free, ties
        add_req(alloc_req(0));
        add_req(alloc_req(64));
        add_req(alloc_req(65));
        add_req(alloc_req(1024));
        add_req(alloc_req(1025));
        add_req(alloc_req(16'hFFFF));
        add_req(free_req(0, 0));
        add_req(free_req(0, 0));
        add_req(free_req(3, 63));
        add_req(free_req(3, 64));
        add_req(free_req(0, 1023));
        add_req(free_req(2, 10'h3FF));
        add_req(alloc_req(600));
        wait_drained();

        write_reg(REG_BYTES0, 100);
        write_reg(REG_BYTES1, 100);
        write_reg(REG_BYTES2, 16'hFFFF);
        write_reg(REG_BYTES3, 0);
        write_reg(REG_COUNT0, 2);
        write_reg(REG_COUNT1, 0);
        write_reg(REG_COUNT2, 1024);
        write_reg(REG_COUNT3, 11'h7FF);
        for (int i = 0; i < 4; i++) add_req(alloc_req(50));
        add_req(alloc_req(0));
        add_req(free_req(0, 1));
        add_req(alloc_req(100));
        add_req(free_req(1, 0));
        add_req(alloc_req(101));
        wait_drained();

        // long receiver stall while sender keeps offering
        hold_off = 1'b1;
        random_phase(40, 200);
        wait (hold_cnt >= HOLD_CYCLES);
        hold_off = 1'b0;
        wait_drained();

        write_reg(REG_COUNT0, 3);
        write_reg(REG_COUNT1, 5);
        write_reg(REG_COUNT2, 1);
        write_reg(REG_COUNT3, 8);
        write_reg(REG_BYTES0, 32);
        write_reg(REG_BYTES1, 256);
        write_reg(REG_BYTES2, 128);
        write_reg(REG_BYTES3, 4096);
        random_phase(400, 5000);
        repeat (200) @(negedge aclk);
        send_pause = 1'b1;
        while (s_valid || expected_rsps.size() != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
        send_pause = 1'b0;
        wait_drained();

        write_reg(REG_COUNT0, 1024);
        write_reg(REG_COUNT1, 0);
        write_reg(REG_COUNT2, 1);
        write_reg(REG_COUNT3, 1024);
        write_reg(REG_BYTES0, 16'hFFFF);
        write_reg(REG_BYTES3, 16'hFFFF);
        random_phase(300, 16'hFFFF);
        wait_drained();

        write_reg(REG_COUNT0, 16);
        write_reg(REG_COUNT1, 16);
        write_reg(REG_COUNT2, 16);
        write_reg(REG_COUNT3, 16);
        write_reg(REG_BYTES0, 64);
        write_reg(REG_BYTES1, 128);
        write_reg(REG_BYTES2, 512);
        write_reg(REG_BYTES3, 1024);
        random_phase(500, 1100);
        wait_drained();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ sim.f @@
src/scba_pkg.sv
src/scba_ram.sv
src/size_class_block_allocator_core.sv
sim/tb_size_class_block_allocator_core.sv
